// ===== rtl/core/ffcd_pkg.sv =====
// Package for the fixed-frame command decoder: frame size, character codes,
// keyword constants and the types passed between the decoder modules.
// No dependencies.
`default_nettype none

package ffcd_pkg;

  // Number of bytes in a frame, the terminating ';' included (6 to 32).
  localparam int unsigned FRAME_BYTES = 13;
  // Bytes held in the frame store: every byte before the terminator.
  localparam int unsigned BUF_DEPTH   = FRAME_BYTES - 1;
  // Byte counter runs 0 .. FRAME_BYTES-1.
  localparam int unsigned CNT_W       = $clog2(FRAME_BYTES);

  localparam logic [7:0] CHAR_SEMI  = 8'h3B;  // ';'
  localparam logic [7:0] CHAR_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'

  // Keywords, first character in the most significant byte.
  localparam logic [31:0] KEY_HALT = "HALT";
  localparam logic [31:0] KEY_DRIV = "DRIV";
  localparam logic [31:0] KEY_TURN = "TURN";
  localparam logic [31:0] KEY_STEP = "STEP";
  localparam logic [31:0] KEY_GRIP = "GRIP";
  localparam logic [31:0] KEY_SAFE = "SAFE";
  localparam logic [31:0] KEY_PING = "PING";

  localparam int unsigned FACTOR_W     = 24;
  localparam logic [FACTOR_W-1:0] FACTOR_RESET = 24'h01_0000;

  // Configuration register indexes (byte address bit 2).
  localparam logic REG_DRIVE = 1'b0;
  localparam logic REG_TURN  = 1'b1;

  typedef enum logic [3:0] {
    KIND_INVALID = 4'd0,
    KIND_ACK     = 4'd1,
    KIND_HALT    = 4'd2,
    KIND_DRIVE   = 4'd3,
    KIND_TURN    = 4'd4,
    KIND_STEP    = 4'd5,
    KIND_GRIP    = 4'd6,
    KIND_SAFE    = 4'd7,
    KIND_PING    = 4'd8
  } kind_e;

  // A decoded frame on its way to the scaling stage.
  typedef struct packed {
    kind_e              kind;
    logic signed [15:0] field_a;
    logic signed [15:0] field_b;
    logic               safety;
  } dec_t;

  typedef struct packed {
    logic [FACTOR_W-1:0] drive_factor;
    logic [FACTOR_W-1:0] turn_factor;
  } cfg_t;

  typedef struct packed {
    kind_e              kind;
    logic signed [15:0] left_steps;
    logic signed [15:0] right_steps;
    logic signed [15:0] gripper_pitch;
    logic signed [15:0] gripper_clamp;
    logic               safety_enabled;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/ffcd_regs.sv =====
// Configuration registers of the command decoder behind an APB-style port.
// Depends on ffcd_pkg for the register indexes and reset values.
`default_nettype none

module ffcd_regs (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [2:0]     paddr,
  input  wire logic [31:0]    pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output ffcd_pkg::cfg_t      cfg_o
);

  ffcd_pkg::cfg_t cfg_q;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.drive_factor <= ffcd_pkg::FACTOR_RESET;
      cfg_q.turn_factor  <= ffcd_pkg::FACTOR_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        ffcd_pkg::REG_DRIVE: cfg_q.drive_factor <= pwdata[ffcd_pkg::FACTOR_W-1:0];
        ffcd_pkg::REG_TURN:  cfg_q.turn_factor  <= pwdata[ffcd_pkg::FACTOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      ffcd_pkg::REG_DRIVE: prdata = {8'd0, cfg_q.drive_factor};
      ffcd_pkg::REG_TURN:  prdata = {8'd0, cfg_q.turn_factor};
      default:             prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/core/ffcd_frame.sv =====
// Input register, frame store, byte counter, keyword and field decode of the
// command decoder. Depends on ffcd_pkg for frame size, keywords and types.
`default_nettype none

module ffcd_frame (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  output logic            dec_valid_o,
  input  wire logic       dec_ready_i,
  output ffcd_pkg::dec_t  dec_o
);

  logic                       in_v_q;
  logic [7:0]                 in_byte_q;
  logic [ffcd_pkg::CNT_W-1:0] count_q;
  logic [7:0]                 buf_q [ffcd_pkg::BUF_DEPTH];
  logic                       safety_q;
  logic                       safety_d;
  logic                       dec_v_q;
  ffcd_pkg::dec_t             dec_q;
  ffcd_pkg::dec_t             dec_d;

  logic                       is_semi;
  logic                       is_last;
  logic                       in_go;
  logic [7:0]                 view [12];
  logic [31:0]                key;
  logic signed [15:0]         val_a;
  logic signed [15:0]         val_b;

  function automatic logic signed [15:0] digit(input logic [7:0] b);
    digit = $signed({8'd0, b}) - $signed({8'd0, ffcd_pkg::CHAR_ZERO});
  endfunction

  function automatic logic signed [15:0] field_value(input logic [7:0] s,
                                                    input logic [7:0] d1,
                                                    input logic [7:0] d2,
                                                    input logic [7:0] d3);
    logic signed [15:0] v;
    v = digit(d1) * 16'sd100 + digit(d2) * 16'sd10 + digit(d3);
    field_value = (s == ffcd_pkg::CHAR_MINUS) ? -v : v;
  endfunction

  assign is_semi    = (in_byte_q == ffcd_pkg::CHAR_SEMI);
  assign is_last    = (count_q == ffcd_pkg::CNT_W'(ffcd_pkg::FRAME_BYTES - 1));
  assign in_go      = in_v_q & (~is_semi | dec_ready_i);
  assign in_ready_o = ~in_v_q | in_go;

  // Frame as seen at decode time: stored bytes, then the terminator itself,
  // then zero bytes for field positions that lie past a short frame.
  for (genvar g = 0; g < 12; g++) begin : g_view
    if (g < ffcd_pkg::BUF_DEPTH) begin : g_buf
      assign view[g] = buf_q[g];
    end else if (g == ffcd_pkg::BUF_DEPTH) begin : g_term
      assign view[g] = in_byte_q;
    end else begin : g_zero
      assign view[g] = 8'd0;
    end
  end

  assign key   = {view[0], view[1], view[2], view[3]};
  assign val_a = field_value(view[4], view[5], view[6], view[7]);
  assign val_b = field_value(view[8], view[9], view[10], view[11]);

  always_comb begin
    dec_d.kind    = ffcd_pkg::KIND_INVALID;
    dec_d.field_a = val_a;
    dec_d.field_b = val_b;
    safety_d      = safety_q;
    if (is_last) begin
      priority case (key)
        ffcd_pkg::KEY_HALT: dec_d.kind = ffcd_pkg::KIND_HALT;
        ffcd_pkg::KEY_DRIV: dec_d.kind = ffcd_pkg::KIND_DRIVE;
        ffcd_pkg::KEY_TURN: dec_d.kind = ffcd_pkg::KIND_TURN;
        ffcd_pkg::KEY_STEP: dec_d.kind = ffcd_pkg::KIND_STEP;
        ffcd_pkg::KEY_GRIP: dec_d.kind = ffcd_pkg::KIND_GRIP;
        ffcd_pkg::KEY_SAFE: begin
          dec_d.kind = ffcd_pkg::KIND_SAFE;
          safety_d   = (val_a != 16'sd0);
        end
        ffcd_pkg::KEY_PING: dec_d.kind = ffcd_pkg::KIND_PING;
        default:            dec_d.kind = ffcd_pkg::KIND_ACK;
      endcase
    end
    dec_d.safety = safety_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q   <= 1'b0;
      count_q  <= '0;
      safety_q <= 1'b0;
      dec_v_q  <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_v_q <= in_valid_i;
      end
      if (in_go) begin
        if (is_semi || is_last) begin
          count_q <= '0;
        end else begin
          count_q <= count_q + 1'b1;
        end
        if (is_semi) begin
          safety_q <= safety_d;
        end
      end
      if (dec_ready_i) begin
        dec_v_q <= in_go & is_semi;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= in_byte_i;
    end
    for (int i = 0; i < ffcd_pkg::BUF_DEPTH; i++) begin
      if (in_go && count_q == ffcd_pkg::CNT_W'(i)) begin
        buf_q[i] <= in_byte_q;
      end
    end
    if (in_go && is_semi) begin
      dec_q <= dec_d;
    end
  end

  assign dec_valid_o = dec_v_q;
  assign dec_o       = dec_q;

endmodule

`default_nettype wire

// ===== rtl/core/ffcd_scale.sv =====
// Step scaling and result register of the command decoder: Q16 multiply,
// truncation toward zero, saturation and per-command field placement.
// Depends on ffcd_pkg for the decoded-frame, configuration and result types.
`default_nettype none

module ffcd_scale (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       dec_valid_i,
  output logic            dec_ready_o,
  input  ffcd_pkg::dec_t  dec_i,
  input  ffcd_pkg::cfg_t  cfg_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output ffcd_pkg::res_t  res_o
);

  localparam int unsigned PROD_W = 15 + ffcd_pkg::FACTOR_W;

  logic                          out_v_q;
  ffcd_pkg::res_t                res_q;
  ffcd_pkg::res_t                res_d;

  logic                          neg;
  logic [14:0]                   mag;
  logic [ffcd_pkg::FACTOR_W-1:0] factor;
  logic [PROD_W-1:0]             prod;
  logic [PROD_W-17:0]            quot;
  logic signed [15:0]            steps;
  logic signed [15:0]            steps_neg;

  // Field magnitudes stay below 2^15, so the absolute value fits 15 bits.
  assign neg    = dec_i.field_a[15];
  assign mag    = neg ? 15'(-dec_i.field_a) : dec_i.field_a[14:0];
  assign factor = (dec_i.kind == ffcd_pkg::KIND_TURN) ? cfg_i.turn_factor
                                                      : cfg_i.drive_factor;
  assign prod   = PROD_W'(mag) * PROD_W'(factor);
  assign quot   = prod[PROD_W-1:16];

  always_comb begin
    if (neg) begin
      steps = (quot > (PROD_W-16)'(32768)) ? -16'sd32768 : -$signed(quot[15:0]);
    end else begin
      steps = (quot > (PROD_W-16)'(32767)) ? 16'sd32767 : $signed(quot[15:0]);
    end
    steps_neg = (steps == -16'sd32768) ? 16'sd32767 : -steps;
  end

  always_comb begin
    res_d.kind           = dec_i.kind;
    res_d.left_steps     = '0;
    res_d.right_steps    = '0;
    res_d.gripper_pitch  = '0;
    res_d.gripper_clamp  = '0;
    res_d.safety_enabled = dec_i.safety;
    unique case (dec_i.kind)
      ffcd_pkg::KIND_DRIVE: begin
        res_d.left_steps  = steps;
        res_d.right_steps = steps;
      end
      ffcd_pkg::KIND_TURN: begin
        res_d.left_steps  = steps_neg;
        res_d.right_steps = steps;
      end
      ffcd_pkg::KIND_STEP: begin
        res_d.left_steps  = dec_i.field_a;
        res_d.right_steps = dec_i.field_b;
      end
      ffcd_pkg::KIND_GRIP: begin
        res_d.gripper_pitch = dec_i.field_a;
        res_d.gripper_clamp = dec_i.field_b;
      end
      default: ;
    endcase
  end

  assign dec_ready_o = ~out_v_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (dec_ready_o) begin
      out_v_q <= dec_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dec_ready_o && dec_valid_i) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ===== rtl/core/fixed_frame_command_decoder_top.sv =====
// Top level of the fixed-frame command decoder.
// Depends on ffcd_pkg, ffcd_regs, ffcd_frame and ffcd_scale.
//
// Received characters arrive one per transaction on the s_axis channel
// (tdata holds the byte). Bytes are gathered into a 13-byte frame ended by
// ';'. A ';' in the last position decodes the four-character keyword and
// gives one command transaction on m_axis; an earlier ';' gives one invalid
// transaction; thirteen bytes without ';' are dropped with no transaction.
// m_axis tuser carries the command kind and tdata the wheel steps, gripper
// values and the stored safety flag.
// A result reaches m_axis through the input register, the decode register
// and the result register after the multiplier.
// Throughput: one byte per cycle, set by the single pass through the decode
// and scaling logic. A receiver that holds m_axis_tready low stalls only
// terminator bytes once the result path is full; other bytes keep flowing.
// Reset clears the byte count, the safety flag and all valid flags, and
// sets both scaling factors to 1.0 (65536 in Q16). The APB registers are
// meant to be written only while no frame is in flight.
`default_nettype none

module fixed_frame_command_decoder_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Received characters.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // Decoded commands.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,   // [15:0] left_steps, [31:16] right_steps,
                                           // [47:32] gripper_pitch,
                                           // [63:48] gripper_clamp,
                                           // [64] safety_enabled, [71:65] zero
  output logic [3:0]       m_axis_tuser,   // [3:0] kind
  // Configuration.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  ffcd_pkg::cfg_t cfg;
  ffcd_pkg::dec_t dec;
  ffcd_pkg::res_t res;
  logic           dec_valid;
  logic           dec_ready;

  ffcd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Frame gathering and keyword decode.
  ffcd_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .dec_valid_o (dec_valid),
    .dec_ready_i (dec_ready),
    .dec_o       (dec)
  );

  // Scaling to wheel steps and the output register.
  ffcd_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dec_valid_i (dec_valid),
    .dec_ready_o (dec_ready),
    .dec_i       (dec),
    .cfg_i       (cfg),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tuser = res.kind;
  assign m_axis_tdata = {7'd0,
                         res.safety_enabled,
                         res.gripper_clamp,
                         res.gripper_pitch,
                         res.right_steps,
                         res.left_steps};

endmodule

`default_nettype wire
